// ===== design/rtqi_pkg.sv =====
// Shared types, constants and helper functions for the curve table
// interpolation unit. No dependencies; every other design file uses it.
`timescale 1ns / 1ps
package rtqi_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    // widest table index carried between front and back (256 entries)
    localparam int IDX_MAX_W      = 8;

    // intermediate saturation limit, 2^61
    localparam logic        [63:0] SAT_MAG = 64'h2000_0000_0000_0000;
    localparam logic signed [63:0] SAT_POS = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] SAT_NEG = 64'shE000_0000_0000_0000;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_BRACKET = 2'd1;
    localparam logic [1:0] STATUS_SAT        = 2'd2;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    // one queued item: x is point_x for a load, query_x for a query
    typedef struct packed {
        t_req                  req;
        logic [IDX_MAX_W-1:0]  idx;
        logic [31:0]           x;
        logic [31:0]           y;
    } t_item;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic signed [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic over61(input logic signed [63:0] v);
        return (v > SAT_POS) || (v < SAT_NEG);
    endfunction

    function automatic logic signed [63:0] clip61(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > SAT_POS) r = SAT_POS;
        if (v < SAT_NEG) r = SAT_NEG;
        return r;
    endfunction

endpackage

// ===== design/curve_table_quadratic_interp_unit.sv =====
// Curve table interpolation unit: a table of MAX_POINTS (x, y) points in
// signed fixed point with FRAC_BITS fraction bits, loaded one point per item,
// and queries that return the piecewise quadratic (or linear) curve value.
// Loads stream at one item per cycle through the four-entry queue while the
// back end is idle; a query in progress stalls the queue. A query reads the end
// points, scans the n points, fetches its triple and checks it; the fitted
// cases add the divider, which yields one quotient bit per cycle (three
// divisions for a quadratic, one for a linear segment), and the multiplier
// (three products for a quadratic, one for a linear segment). End points and
// exact matches skip the fitting. The result waits in an output register
// while the front keeps accepting items until its queue is full. Depends on
// rtqi_pkg and submodules.
`timescale 1ns / 1ps
module curve_table_quadratic_interp_unit #(
    parameter int MAX_POINTS = rtqi_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = rtqi_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_wdata,  // point_count
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // point_index[3:0], point_x[35:4], point_y[67:36], query_x[99:68], zero pad
    input  logic [103:0] i_s_tdata,
    // req_type[0]
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // value[31:0], status[33:32], zero pad
    output logic [39:0]  o_m_tdata
);
    logic [4:0]      r_point_count;
    logic            q_valid, q_pop;
    rtqi_pkg::t_item q_item;

    // hold the point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 5'd1;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    rtqi_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_valid   (q_valid),
        .o_item    (q_item),
        .i_pop     (q_pop)
    );

    rtqi_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point_count(r_point_count),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );
endmodule

// ===== design/rtqi_front.sv =====
// Front end: accepts stream items, classifies loads and queries, drops loads
// beyond the table and queues the rest for the back end. Uses rtqi_pkg.
`timescale 1ns / 1ps
module rtqi_front #(
    parameter int MAX_POINTS = rtqi_pkg::MAX_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [103:0]   i_s_tdata,
    input  logic [0:0]     i_s_tuser,
    output logic           o_valid,
    output rtqi_pkg::t_item o_item,
    input  logic           i_pop
);
    localparam int DEPTH = 4;

    rtqi_pkg::t_item r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, keep;
    rtqi_pkg::t_item item;

    // classify the incoming item
    always_comb begin
        item.req = rtqi_pkg::t_req'(i_s_tuser[0]);
        item.idx = {4'd0, i_s_tdata[3:0]};
        item.x   = (item.req == rtqi_pkg::REQ_QUERY) ? i_s_tdata[99:68] : i_s_tdata[35:4];
        item.y   = i_s_tdata[67:36];
        keep     = (item.req == rtqi_pkg::REQ_QUERY) ||
                   ({1'b0, item.idx} < 9'(MAX_POINTS));
    end

    assign o_s_tready = (r_cnt != 3'(DEPTH));
    assign push       = i_s_tvalid && o_s_tready && keep;
    assign o_valid    = (r_cnt != 3'd0);
    assign o_item     = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(i_pop);
        end
    end
endmodule

// ===== design/rtqi_div.sv =====
// Rounding signed divider, one quotient bit per cycle, saturating at 2^61.
// Uses rtqi_pkg.
`timescale 1ns / 1ps
module rtqi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quo,
    output logic               o_sat
);
    logic        r_busy, r_done, r_neg, r_sat;
    logic [6:0]  r_cnt;
    logic [64:0] r_rem;
    logic [63:0] r_quo, r_den;
    logic signed [63:0] r_res;
    logic [64:0] rem_sh;
    logic        rem_ge, q_over;
    logic [63:0] q_rnd, q_mag;

    // one restoring step, and the final round and clamp
    always_comb begin
        rem_sh = {r_rem[63:0], r_quo[63]};
        rem_ge = rem_sh >= {1'b0, r_den};
        q_rnd  = r_quo + 64'({r_rem[63:0], 1'b0} >= {1'b0, r_den});
        q_over = q_rnd > rtqi_pkg::SAT_MAG;
        q_mag  = q_over ? rtqi_pkg::SAT_MAG : q_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_rem  <= '0;
                r_quo  <= rtqi_pkg::mag64(i_num);
                r_den  <= rtqi_pkg::mag64(i_den);
                r_neg  <= i_num[63] ^ i_den[63];
            end else if (r_busy) begin
                if (r_cnt != 7'd0) begin
                    r_rem <= rem_ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                    r_quo <= {r_quo[62:0], rem_ge};
                    r_cnt <= r_cnt - 7'd1;
                end else begin
                    r_res  <= $signed(r_neg ? (64'd0 - q_mag) : q_mag);
                    r_sat  <= q_over;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_res;
    assign o_sat  = r_sat;
endmodule

// ===== design/rtqi_mul.sv =====
// Fixed-point multiplier: four 32x32 partial products accumulated in turn, then
// a rounding rescale by FRAC_BITS with saturation at 2^61. Uses rtqi_pkg.
`timescale 1ns / 1ps
module rtqi_mul #(
    parameter int FRAC_BITS = rtqi_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_prod,
    output logic               o_sat
);
    logic         r_busy, r_done, r_neg, r_sat;
    logic [2:0]   r_cnt;
    logic [63:0]  r_ua, r_ub;
    logic [127:0] r_acc;
    logic signed [63:0] r_res;
    logic [31:0]  ah, bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh, sum, shr;
    logic         over;
    logic [63:0]  pmag;

    // select partial product and place it
    always_comb begin
        ah  = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
        bh  = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
        pp  = ah * bh;
        case (r_cnt[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        sum  = r_acc + (128'd1 << (FRAC_BITS - 1));
        shr  = sum >> FRAC_BITS;
        over = shr > {64'd0, rtqi_pkg::SAT_MAG};
        pmag = over ? rtqi_pkg::SAT_MAG : shr[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_ua   <= rtqi_pkg::mag64(i_a);
                r_ub   <= rtqi_pkg::mag64(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_res  <= $signed(r_neg ? (64'd0 - pmag) : pmag);
                    r_sat  <= over;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_res;
    assign o_sat  = r_sat;
endmodule

// ===== design/rtqi_back.sv =====
// Back end: point table, lookup sequencer and output register. Runs the
// scan, the bracket pick and the slope arithmetic on rtqi_div and rtqi_mul.
`timescale 1ns / 1ps
module rtqi_back #(
    parameter int MAX_POINTS = rtqi_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = rtqi_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_point_count,
    input  logic            i_valid,
    input  rtqi_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [39:0]     o_m_tdata
);
    localparam int IDX_W = $clog2(MAX_POINTS);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001, S_ONE  = 20'h00002, S_RD0  = 20'h00004,
        S_RDN  = 20'h00008, S_SCAN = 20'h00010, S_PICK = 20'h00020,
        S_T1   = 20'h00040, S_T2   = 20'h00080, S_T3   = 20'h00100,
        S_QCHK = 20'h00200, S_LIN  = 20'h00400, S_LD   = 20'h00800,
        S_LM   = 20'h01000, S_D1   = 20'h02000, S_D2   = 20'h04000,
        S_D3   = 20'h08000, S_M1   = 20'h10000, S_M2   = 20'h20000,
        S_M3   = 20'h40000, S_FIN  = 20'h80000
    } t_state;

    t_state r_state;
    logic [31:0] r_mem_x [MAX_POINTS];
    logic [31:0] r_mem_y [MAX_POINTS];
    logic [IDX_W-1:0] rd_addr, i1, r_j, r_last, r_ti;
    logic signed [31:0] r_rdx, r_rdy, r_q, r_x0, r_y0, r_px, r_py;
    logic signed [31:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    logic r_asc, r_found, r_sat, r_nobr;
    logic signed [63:0] r_res, r_s1, r_p, r_f;
    logic r_dstart, r_mstart;
    logic signed [63:0] r_dnum, r_dden, r_ma, r_mb;
    logic d_done, d_sat, m_done, m_sat;
    logic signed [63:0] d_quo, m_prod;
    logic r_ovalid;
    logic [31:0] r_oval;
    logic [1:0] r_ostat;
    logic [8:0] cnt9, n9;
    logic [IDX_W:0] n;
    logic signed [63:0] q64, dq1, dq2, slope_a, slope_b, sdiff, sup, lsum;
    logic sup_sat, brk, out_free;

    // clamp the point count into 1..MAX_POINTS
    always_comb begin
        cnt9 = {4'd0, i_point_count};
        if (cnt9 == 9'd0) n9 = 9'd1;
        else if (cnt9 > 9'(MAX_POINTS)) n9 = 9'(MAX_POINTS);
        else n9 = cnt9;
        n = n9[IDX_W:0];
    end

    // arithmetic operands
    always_comb begin
        q64     = rtqi_pkg::sx32(r_q);
        dq1     = q64 - rtqi_pkg::sx32(r_x1);
        dq2     = q64 - rtqi_pkg::sx32(r_x2);
        slope_a = (rtqi_pkg::sx32(r_y2) - rtqi_pkg::sx32(r_y1)) <<< FRAC_BITS;
        slope_b = (rtqi_pkg::sx32(r_y3) - rtqi_pkg::sx32(r_y2)) <<< FRAC_BITS;
        sdiff   = d_quo - r_s1;
        sup_sat = rtqi_pkg::mag64(sdiff) > (rtqi_pkg::SAT_MAG >> FRAC_BITS);
        sup     = sup_sat ? (sdiff[63] ? rtqi_pkg::SAT_NEG : rtqi_pkg::SAT_POS)
                          : (sdiff <<< FRAC_BITS);
        lsum    = rtqi_pkg::sx32(r_y1) + m_prod;
        brk     = r_asc ? (r_q > r_px && r_q < r_rdx) : (r_q < r_px && r_q > r_rdx);
        i1      = (r_last == '0) ? '0 : r_last - 1'b1;
        out_free = !r_ovalid || i_m_tready;
    end

    // table read address for the next cycle
    always_comb begin
        case (r_state)
            S_RD0:   rd_addr = IDX_W'(n - 1'b1);
            S_SCAN:  rd_addr = r_j + 1'b1;
            S_PICK:  rd_addr = i1;
            S_T1:    rd_addr = r_ti + 1'b1;
            S_T2:    rd_addr = r_ti + IDX_W'(2);
            default: rd_addr = '0;
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && i_valid;

    // table write on load, registered read
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.req == rtqi_pkg::REQ_LOAD) begin
            r_mem_x[i_item.idx[IDX_W-1:0]] <= i_item.x;
            r_mem_y[i_item.idx[IDX_W-1:0]] <= i_item.y;
        end
        r_rdx <= r_mem_x[rd_addr];
        r_rdy <= r_mem_y[rd_addr];
    end

    // lookup sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            r_mstart <= 1'b0;
            if (r_ovalid && i_m_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_item.req == rtqi_pkg::REQ_QUERY) begin
                        r_q     <= i_item.x;
                        r_sat   <= 1'b0;
                        r_nobr  <= 1'b0;
                        r_found <= 1'b0;
                        r_last  <= '0;
                        r_state <= (n == (IDX_W+1)'(1)) ? S_ONE : S_RD0;
                    end
                end
                S_ONE: begin
                    r_res   <= rtqi_pkg::sx32(r_rdy);
                    r_state <= S_FIN;
                end
                S_RD0: begin
                    r_x0    <= r_rdx;
                    r_y0    <= r_rdy;
                    r_state <= S_RDN;
                end
                S_RDN: begin
                    r_asc <= r_x0 <= r_rdx;
                    if ((r_x0 <= r_rdx) ? (r_q < r_x0) : (r_q > r_x0)) begin
                        r_res   <= rtqi_pkg::sx32(r_y0);
                        r_state <= S_FIN;
                    end else if ((r_x0 <= r_rdx) ? (r_q > r_rdx) : (r_q < r_rdx)) begin
                        r_res   <= rtqi_pkg::sx32(r_rdy);
                        r_state <= S_FIN;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_px <= r_rdx;
                    r_py <= r_rdy;
                    if (r_q == r_rdx) begin
                        r_res   <= rtqi_pkg::sx32(r_rdy);
                        r_state <= S_FIN;
                    end else if (r_j != '0 && brk && n == (IDX_W+1)'(2)) begin
                        r_x1    <= r_px;
                        r_y1    <= r_py;
                        r_x2    <= r_rdx;
                        r_y2    <= r_rdy;
                        r_state <= S_LIN;
                    end else begin
                        if (r_j != '0 && brk) begin
                            r_last  <= r_j - 1'b1;
                            r_found <= 1'b1;
                        end
                        if ({1'b0, r_j} == n - 1'b1) r_state <= S_PICK;
                        else r_j <= r_j + 1'b1;
                    end
                end
                S_PICK: begin
                    r_ti <= i1;
                    if (!r_found) begin
                        r_res   <= '0;
                        r_nobr  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    r_x1    <= r_rdx;
                    r_y1    <= r_rdy;
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_x2    <= r_rdx;
                    r_y2    <= r_rdy;
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_x3    <= r_rdx;
                    r_y3    <= r_rdy;
                    r_state <= S_QCHK;
                end
                S_QCHK: begin
                    if ((r_x1 < r_x3 && r_q > r_x3) || (r_x1 > r_x3 && r_q < r_x3)) begin
                        r_res   <= rtqi_pkg::sx32(r_y3);
                        r_state <= S_FIN;
                    end else if ((r_x1 < r_x3 && r_q < r_x1) ||
                                 (r_x1 > r_x3 && r_q > r_x1)) begin
                        r_res   <= rtqi_pkg::sx32(r_y1);
                        r_state <= S_FIN;
                    end else if (r_x2 == r_x1 || r_x3 == r_x2 || r_x1 == r_x3) begin
                        r_state <= S_LIN;
                    end else begin
                        r_dnum   <= slope_a;
                        r_dden   <= rtqi_pkg::sx32(r_x2) - rtqi_pkg::sx32(r_x1);
                        r_dstart <= 1'b1;
                        r_state  <= S_D1;
                    end
                end
                S_LIN: begin
                    if ((r_x1 < r_x2 && r_q > r_x2) || (r_x1 > r_x2 && r_q < r_x2)) begin
                        r_res   <= rtqi_pkg::sx32(r_y2);
                        r_state <= S_FIN;
                    end else if ((r_x1 < r_x2 && r_q < r_x1) ||
                                 (r_x1 > r_x2 && r_q > r_x1) || r_x1 == r_x2) begin
                        r_res   <= rtqi_pkg::sx32(r_y1);
                        r_state <= S_FIN;
                    end else begin
                        r_dnum   <= slope_a;
                        r_dden   <= rtqi_pkg::sx32(r_x2) - rtqi_pkg::sx32(r_x1);
                        r_dstart <= 1'b1;
                        r_state  <= S_LD;
                    end
                end
                S_LD: begin
                    if (d_done) begin
                        r_sat    <= r_sat | d_sat;
                        r_ma     <= d_quo;
                        r_mb     <= dq1;
                        r_mstart <= 1'b1;
                        r_state  <= S_LM;
                    end
                end
                S_LM: begin
                    if (m_done) begin
                        r_sat   <= r_sat | m_sat | rtqi_pkg::over61(lsum);
                        r_res   <= rtqi_pkg::clip61(lsum);
                        r_state <= S_FIN;
                    end
                end
                S_D1: begin
                    if (d_done) begin
                        r_sat    <= r_sat | d_sat;
                        r_s1     <= d_quo;
                        r_dnum   <= slope_b;
                        r_dden   <= rtqi_pkg::sx32(r_x3) - rtqi_pkg::sx32(r_x2);
                        r_dstart <= 1'b1;
                        r_state  <= S_D2;
                    end
                end
                S_D2: begin
                    if (d_done) begin
                        r_sat    <= r_sat | d_sat | sup_sat;
                        r_dnum   <= sup;
                        r_dden   <= rtqi_pkg::sx32(r_x3) - rtqi_pkg::sx32(r_x1);
                        r_dstart <= 1'b1;
                        r_state  <= S_D3;
                    end
                end
                S_D3: begin
                    if (d_done) begin
                        r_sat    <= r_sat | d_sat;
                        r_ma     <= d_quo;
                        r_mb     <= dq1;
                        r_mstart <= 1'b1;
                        r_state  <= S_M1;
                    end
                end
                S_M1: begin
                    if (m_done) begin
                        r_sat    <= r_sat | m_sat;
                        r_p      <= m_prod;
                        r_ma     <= r_s1;
                        r_mb     <= dq1;
                        r_mstart <= 1'b1;
                        r_state  <= S_M2;
                    end
                end
                S_M2: begin
                    if (m_done) begin
                        r_sat    <= r_sat | m_sat | rtqi_pkg::over61(lsum);
                        r_f      <= rtqi_pkg::clip61(lsum);
                        r_ma     <= r_p;
                        r_mb     <= dq2;
                        r_mstart <= 1'b1;
                        r_state  <= S_M3;
                    end
                end
                S_M3: begin
                    if (m_done) begin
                        r_sat   <= r_sat | m_sat | rtqi_pkg::over61(r_f + m_prod);
                        r_res   <= rtqi_pkg::clip61(r_f + m_prod);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // clamp to 32 bits and hand to the output register
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_res > 64'sh0000_0000_7FFF_FFFF) begin
                            r_oval  <= 32'h7FFF_FFFF;
                            r_ostat <= rtqi_pkg::STATUS_SAT;
                        end else if (r_res < -64'sh0000_0000_8000_0000) begin
                            r_oval  <= 32'h8000_0000;
                            r_ostat <= rtqi_pkg::STATUS_SAT;
                        end else begin
                            r_oval  <= r_res[31:0];
                            r_ostat <= r_nobr ? rtqi_pkg::STATUS_NO_BRACKET :
                                       r_sat  ? rtqi_pkg::STATUS_SAT : rtqi_pkg::STATUS_OK;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    rtqi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dstart),
        .i_num  (r_dnum),
        .i_den  (r_dden),
        .o_done (d_done),
        .o_quo  (d_quo),
        .o_sat  (d_sat)
    );

    rtqi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_mstart),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_done (m_done),
        .o_prod (m_prod),
        .o_sat  (m_sat)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_ostat, r_oval};
endmodule
